// ===== hdl/sb7seg_pkg.sv =====
// shared types, constants and glyph functions for the signed binary to
// seven-segment converter; no dependencies
package sb7seg_pkg;

  localparam int VALUE_W         = 32;
  localparam int SEG_W           = 7;
  localparam int COUNT_W         = 4;
  localparam int OUT_POSITIONS   = 8;
  localparam int MAX_DIGITS      = 10;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int SYMBOL_POSITIONS_DEF = 8;

  // double dabble split: steps per stage times stages covers every input bit
  localparam int DD_STEPS  = 8;
  localparam int DD_STAGES = VALUE_W / DD_STEPS;

  localparam int ERR_SYMBOLS = 5;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [SEG_W-1:0] SEG_E     = 7'h79;
  localparam logic [SEG_W-1:0] SEG_R     = 7'h50;
  localparam logic [SEG_W-1:0] SEG_O     = 7'h5C;

  // conversion state carried through the double dabble stages
  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  // after digit count, before glyph lookup
  typedef struct packed {
    logic               neg;
    logic               err;
    logic [COUNT_W-1:0] total;
    logic [BCD_W-1:0]   bcd;
  } cnt_t;

  // one finished result beat
  typedef struct packed {
    logic [OUT_POSITIONS-1:0][SEG_W-1:0] seg;
    logic [COUNT_W-1:0]                  count;
    logic                                err;
  } res_t;

  // one shift-and-add-3 step
  function automatic dd_t dd_step(dd_t s);
    dd_t r;
    logic [BCD_W-1:0] adj;
    r = s;
    adj = s.bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (s.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = s.bcd[4*i +: 4] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {adj[BCD_W-2:0], s.bin, 1'b0};
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] digit_glyph(logic [3:0] d);
    logic [SEG_W-1:0] g;
    case (d)
      4'd0: g = 7'h3F;
      4'd1: g = 7'h06;
      4'd2: g = 7'h5B;
      4'd3: g = 7'h4F;
      4'd4: g = 7'h66;
      4'd5: g = 7'h6D;
      4'd6: g = 7'h7D;
      4'd7: g = 7'h07;
      4'd8: g = 7'h7F;
      4'd9: g = 7'h6F;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  // "E r r o r" pattern by position
  function automatic logic [SEG_W-1:0] err_glyph(int unsigned k);
    logic [SEG_W-1:0] g;
    case (k)
      0: g = SEG_E;
      1: g = SEG_R;
      2: g = SEG_R;
      3: g = SEG_O;
      4: g = SEG_R;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/sb7seg_dd_stage.sv =====
// one double dabble pipeline stage: DD_STEPS shift-and-add-3 steps, registered
// depends on sb7seg_pkg
module sb7seg_dd_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sb7seg_pkg::dd_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sb7seg_pkg::dd_t   out_data
);

  sb7seg_pkg::dd_t data_next;
  logic            valid;
  sb7seg_pkg::dd_t data;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < sb7seg_pkg::DD_STEPS; i++) begin
      data_next = sb7seg_pkg::dd_step(data_next);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== hdl/sb7seg_format.sv =====
// digit count, overflow check and glyph placement, two register stages
// depends on sb7seg_pkg
module sb7seg_format #(
  parameter int SYMBOL_POSITIONS = sb7seg_pkg::SYMBOL_POSITIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sb7seg_pkg::dd_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sb7seg_pkg::res_t  out_data
);

  // count stage
  sb7seg_pkg::cnt_t cnt_next;
  sb7seg_pkg::cnt_t cnt;
  logic             cnt_valid;
  logic             cnt_ready;
  logic [sb7seg_pkg::COUNT_W-1:0] nd;

  // output stage
  sb7seg_pkg::res_t res_next;
  sb7seg_pkg::res_t res;
  logic             res_valid;
  logic             res_ready;

  always_comb begin
    nd = 4'd1;
    for (int i = 1; i < sb7seg_pkg::MAX_DIGITS; i++) begin
      if (in_data.bcd[4*i +: 4] != 4'd0) begin
        nd = sb7seg_pkg::COUNT_W'(i + 1);
      end
    end
    cnt_next.neg   = in_data.neg;
    cnt_next.bcd   = in_data.bcd;
    cnt_next.total = nd + sb7seg_pkg::COUNT_W'(in_data.neg);
    cnt_next.err   = cnt_next.total > sb7seg_pkg::COUNT_W'(SYMBOL_POSITIONS);
  end

  assign in_ready = !cnt_valid || cnt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= 1'b0;
    end else if (in_ready) begin
      cnt_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cnt <= cnt_next;
    end
  end

  // symbol k shows digit total-1-k; the minus takes slot 0
  always_comb begin
    logic [sb7seg_pkg::COUNT_W-1:0] p;
    logic [3:0]                     d;
    res_next.err   = cnt.err;
    res_next.count = cnt.err ? sb7seg_pkg::COUNT_W'(sb7seg_pkg::ERR_SYMBOLS) : cnt.total;
    for (int k = 0; k < sb7seg_pkg::OUT_POSITIONS; k++) begin
      p = cnt.total - 4'd1 - sb7seg_pkg::COUNT_W'(k);
      d = 4'(cnt.bcd >> {p, 2'b00});
      if (cnt.err) begin
        res_next.seg[k] = sb7seg_pkg::err_glyph(k);
      end else if (sb7seg_pkg::COUNT_W'(k) >= cnt.total) begin
        res_next.seg[k] = sb7seg_pkg::SEG_BLANK;
      end else if (cnt.neg && k == 0) begin
        res_next.seg[k] = sb7seg_pkg::SEG_MINUS;
      end else begin
        res_next.seg[k] = sb7seg_pkg::digit_glyph(d);
      end
    end
  end

  assign res_ready = !res_valid || out_ready;
  assign cnt_ready = res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= cnt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && cnt_valid) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res;

endmodule

// ===== hdl/signed_binary_to_seven_segment.sv =====
// top level: signed 32-bit value to a row of seven-segment glyphs
// depends on sb7seg_pkg, sb7seg_dd_stage, sb7seg_format
//
//   channel   signals                                   beat
//   value     value_valid / value_ready / value         one signed integer
//   result    result_valid / result_ready / segments_*,  one display row
//             symbol_count, overflow_error
//
// one beat enters per cycle while result_ready keeps the pipe moving; seven register
// stages (sign/magnitude register, four double dabble stages of 8 steps, count stage,
// glyph/output register); the double dabble chain sets the depth
// rst is synchronous and clears only the valid bits; payload registers hold junk
// a stall at result_ready backs up stage by stage; every stage keeps its beat
// until the next stage takes it, so nothing is dropped or repeated
module signed_binary_to_seven_segment #(
  parameter int SYMBOL_POSITIONS = sb7seg_pkg::SYMBOL_POSITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  output logic                          value_ready,
  input  logic signed [31:0]            value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [6:0]                    segments_0,
  output logic [6:0]                    segments_1,
  output logic [6:0]                    segments_2,
  output logic [6:0]                    segments_3,
  output logic [6:0]                    segments_4,
  output logic [6:0]                    segments_5,
  output logic [6:0]                    segments_6,
  output logic [6:0]                    segments_7,
  output logic [3:0]                    symbol_count,
  output logic                          overflow_error
);

  // sign/magnitude stage
  logic            sm_valid;
  logic            sm_ready;
  sb7seg_pkg::dd_t sm;
  sb7seg_pkg::dd_t sm_next;

  // double dabble chain: index 0 is the sign/magnitude stage output
  logic            ch_valid [sb7seg_pkg::DD_STAGES+1];
  logic            ch_ready [sb7seg_pkg::DD_STAGES+1];
  sb7seg_pkg::dd_t ch_data  [sb7seg_pkg::DD_STAGES+1];

  sb7seg_pkg::res_t res;

  // magnitude formed as unsigned, so the most negative value needs no extra bit
  always_comb begin
    sm_next.neg = value[31];
    sm_next.bcd = '0;
    sm_next.bin = value[31] ? (32'd0 - 32'(value)) : 32'(value);
  end

  assign value_ready = !sm_valid || sm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else if (value_ready) begin
      sm_valid <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (value_ready && value_valid) begin
      sm <= sm_next;
    end
  end

  assign ch_valid[0] = sm_valid;
  assign ch_data[0]  = sm;
  assign sm_ready    = ch_ready[0];

  for (genvar s = 0; s < sb7seg_pkg::DD_STAGES; s++) begin : g_dd
    sb7seg_dd_stage u_dd (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (ch_valid[s]),
      .in_ready  (ch_ready[s]),
      .in_data   (ch_data[s]),
      .out_valid (ch_valid[s+1]),
      .out_ready (ch_ready[s+1]),
      .out_data  (ch_data[s+1])
    );
  end

  // digit count and glyph placement, ends in the output register
  sb7seg_format #(
    .SYMBOL_POSITIONS (SYMBOL_POSITIONS)
  ) u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ch_valid[sb7seg_pkg::DD_STAGES]),
    .in_ready  (ch_ready[sb7seg_pkg::DD_STAGES]),
    .in_data   (ch_data[sb7seg_pkg::DD_STAGES]),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (res)
  );

  assign segments_0     = res.seg[0];
  assign segments_1     = res.seg[1];
  assign segments_2     = res.seg[2];
  assign segments_3     = res.seg[3];
  assign segments_4     = res.seg[4];
  assign segments_5     = res.seg[5];
  assign segments_6     = res.seg[6];
  assign segments_7     = res.seg[7];
  assign symbol_count   = res.count;
  assign overflow_error = res.err;

  // an error row always reports five symbols and starts with E
  a_err_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow_error |-> symbol_count == 4'd5 && segments_0 == sb7seg_pkg::SEG_E)
    else $error("error row malformed");

  // a good row uses between one and the allowed number of symbols
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !overflow_error |->
      symbol_count != 4'd0 && symbol_count <= 4'(SYMBOL_POSITIONS))
    else $error("symbol count out of range");

  // the leftmost position of a good row is never blank
  a_lead_symbol: assert property (@(posedge clk) disable iff (rst)
    result_valid && !overflow_error |-> segments_0 != sb7seg_pkg::SEG_BLANK)
    else $error("leftmost symbol blank");

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule
